// ===== sv/ptrd_pkg.sv =====
// Shared types and constants for the planar tile row decoder.
`default_nettype none

package ptrd_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic CMD_TILE   = 1'b0;
    localparam logic CMD_SPRITE = 1'b1;

    typedef logic [3:0]        t_pal;
    typedef logic [SLOT_W-1:0] t_slot;

    // request to the slot table: start a lookup-or-insert
    typedef struct packed {
        logic  start;
        logic  sprite;
        t_pal  pal;
    } t_slot_req;

    // answer from the slot table: one-cycle done pulse with the slot
    typedef struct packed {
        logic  done;
        t_slot slot;
    } t_slot_rsp;

endpackage

`default_nettype wire

// ===== sv/ptrd_slot_table.sv =====
// Tile and sprite palette slot tables with a single shared scan comparator.
`default_nettype none

module ptrd_slot_table
    import ptrd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_slot_req i_req,
    output t_slot_rsp      o_rsp
);

    localparam logic SL_IDLE = 1'b0;
    localparam logic SL_SCAN = 1'b1;

    localparam t_slot SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    t_pal                  r_tile_codes [SLOT_COUNT];
    t_pal                  r_spr_codes  [SLOT_COUNT];
    logic [SLOT_CNT_W-1:0] r_tile_cnt;
    logic [SLOT_CNT_W-1:0] r_spr_cnt;

    logic                  r_state;
    logic                  n_state;
    logic [SLOT_CNT_W-1:0] r_idx;
    logic                  r_sprite;
    t_pal                  r_pal;
    logic                  r_done;
    t_slot                 r_slot;
    t_slot                 n_slot;

    logic [SLOT_CNT_W-1:0] w_cnt;
    t_pal                  w_code;
    logic                  w_end;
    logic                  w_hit;
    logic                  w_insert;

    assign w_cnt    = r_sprite ? r_spr_cnt : r_tile_cnt;
    assign w_code   = r_sprite ? r_spr_codes[r_idx[SLOT_W-1:0]]
                               : r_tile_codes[r_idx[SLOT_W-1:0]];
    assign w_end    = (r_idx == w_cnt);
    assign w_hit    = !w_end && (w_code == r_pal);
    // top bit of the count set means the table is full
    assign w_insert = (r_state == SL_SCAN) && w_end && !w_cnt[SLOT_CNT_W-1];

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        unique case (r_state)
            SL_IDLE: begin
                if (i_req.start) begin
                    n_state = SL_SCAN;
                end
            end
            SL_SCAN: begin
                if (w_hit) begin
                    n_state = SL_IDLE;
                    n_slot  = r_idx[SLOT_W-1:0];
                end else if (w_end) begin
                    n_state = SL_IDLE;
                    n_slot  = w_cnt[SLOT_CNT_W-1] ? SLOT_LAST : w_cnt[SLOT_W-1:0];
                end
            end
            default: n_state = SL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SL_IDLE;
            r_done     <= 1'b0;
            r_idx      <= '0;
            r_tile_cnt <= '0;
            r_spr_cnt  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SL_SCAN) && (w_hit || w_end);
            if (r_state == SL_IDLE) begin
                r_idx <= '0;
            end else if (!w_hit && !w_end) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_insert) begin
                if (r_sprite) begin
                    r_spr_cnt <= r_spr_cnt + 1'b1;
                end else begin
                    r_tile_cnt <= r_tile_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if ((r_state == SL_IDLE) && i_req.start) begin
            r_sprite <= i_req.sprite;
            r_pal    <= i_req.pal;
        end
        if (w_insert) begin
            if (r_sprite) begin
                r_spr_codes[w_cnt[SLOT_W-1:0]] <= r_pal;
            end else begin
                r_tile_codes[w_cnt[SLOT_W-1:0]] <= r_pal;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_slot;

endmodule

`default_nettype wire

// ===== sv/planar_tile_row_decoder_top.sv =====
// Planar pattern row to 4-bit chunky pixel converter, top level.
// One word in is one pattern row: a tile row (tuser 0) gives 8 pixels from the low and
// high bytes of plane_a/plane_b, a sprite row (tuser 1) gives 16 pixels from the four
// plane words, most significant bit first. Before any pixel leaves, the row's palette
// number is looked up in the tile or sprite slot table (inserted on a miss) by a single
// comparator that steps through the table one entry a cycle. The scan takes as many steps
// as the matching entry's position plus one on a hit, or the table's fill plus one on a
// miss (1 to 17). Pixels then leave one a cycle from the plane shift registers while the
// output accepts them; output back-pressure holds them. s_tready is high only while the
// block is idle, and a new row may be taken while the final pixel of the previous one
// still waits on the output.
`default_nettype none

module planar_tile_row_decoder_top
    import ptrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [3:0] palette_number, [19:4] plane_a, [35:20] plane_b,
    // [51:36] plane_c, [67:52] plane_d, [71:68] zero
    input  wire logic [71:0] i_s_tdata,
    // [0] command
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [3:0] pixel_value, [12:4] cram_index, [16:13] palette_slot, [23:17] zero
    output logic [23:0]      o_m_tdata,
    // [0] transparent
    output logic             o_m_tuser,
    // last_pixel
    output logic             o_m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [3:0] TILE_LAST   = 4'd7;
    localparam logic [3:0] SPRITE_LAST = 4'd15;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic        r_sprite;
    t_pal        r_pal;
    t_slot       r_slot;
    logic [15:0] r_pa;
    logic [15:0] r_pb;
    logic [15:0] r_pc;
    logic [15:0] r_pd;
    logic [3:0]  r_pix_cnt;

    logic        r_out_valid;
    logic [3:0]  r_out_px;
    logic [8:0]  r_out_cram;
    t_slot       r_out_slot;
    logic        r_out_transp;
    logic        r_out_last;

    t_slot_req   w_req;
    t_slot_rsp   w_rsp;
    logic        w_in_acc;
    logic        w_load;
    logic [3:0]  w_px;
    logic        w_last;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_req.start  = w_in_acc;
    assign w_req.sprite = i_s_tuser;
    assign w_req.pal    = i_s_tdata[3:0];

    ptrd_slot_table u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // planes shift left one bit a pixel, so bits 15 and 7 always hold the current column
    assign w_px = r_sprite ? {r_pd[15], r_pc[15], r_pb[15], r_pa[15]}
                           : {r_pb[15], r_pb[7], r_pa[15], r_pa[7]};
    assign w_last = (r_pix_cnt == (r_sprite ? SPRITE_LAST : TILE_LAST));
    assign w_load = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pix_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_LOOK) begin
                r_pix_cnt <= '0;
            end else if (w_load) begin
                r_pix_cnt <= r_pix_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sprite <= i_s_tuser;
            r_pal    <= i_s_tdata[3:0];
            r_pa     <= i_s_tdata[19:4];
            r_pb     <= i_s_tdata[35:20];
            r_pc     <= i_s_tdata[51:36];
            r_pd     <= i_s_tdata[67:52];
        end else if (w_load) begin
            r_pa <= {r_pa[14:0], 1'b0};
            r_pb <= {r_pb[14:0], 1'b0};
            r_pc <= {r_pc[14:0], 1'b0};
            r_pd <= {r_pd[14:0], 1'b0};
        end
        if ((r_state == ST_LOOK) && w_rsp.done) begin
            r_slot <= w_rsp.slot;
        end
        if (w_load) begin
            r_out_px     <= w_px;
            // sprite rows sit in the upper half of colour RAM
            r_out_cram   <= {r_sprite, r_pal, w_px};
            r_out_slot   <= r_slot;
            r_out_transp <= (r_sprite == CMD_SPRITE) && (w_px == 4'd0);
            r_out_last   <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_slot, r_out_cram, r_out_px};
    assign o_m_tuser  = r_out_transp;
    assign o_m_tlast  = r_out_last;

    a_tile_opaque : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[12]) |-> !o_m_tuser)
        else $error("tile pixel marked transparent");

    a_done_in_look : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_LOOK))
        else $error("slot table answer outside lookup");

    a_accept_look : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_LOOK))
        else $error("accepted row did not start a lookup");

    a_last_leaves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (o_m_tvalid && o_m_tlast && (r_state == ST_IDLE)))
        else $error("final pixel not presented as last");

endmodule

`default_nettype wire

// ===== test/tb_planar_tile_row_decoder_top.sv =====
// Self-checking testbench for the planar tile row decoder: random rows, random stalls.
`default_nettype none

module tb_planar_tile_row_decoder_top
    import ptrd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ROWS = 500;
    localparam int CALM_ROWS   = 40;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        cmd;
        t_pal        pal;
        logic [15:0] plane_a;
        logic [15:0] plane_b;
        logic [15:0] plane_c;
        logic [15:0] plane_d;
    } t_row;

    typedef struct packed {
        logic [3:0] value;
        logic [8:0] cram;
        logic       transp;
        t_slot      slot;
        logic       last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    t_row   rows_pending[$];
    t_pixel pixels_due[$];
    t_row   row_on_bus;

    // palette numbers held by each slot, per table
    t_pal   tile_pal_of_slot[SLOT_COUNT];
    t_pal   sprite_pal_of_slot[SLOT_COUNT];
    int     tile_slots_used = 0;
    int     sprite_slots_used = 0;

    int     mismatches = 0;
    int     cycles = 0;
    logic   calm = 1'b0;
    int     src_gap_pct = 20;
    int     sink_gap_pct = 20;
    int     src_hold = 0;
    int     sink_hold = 0;

    planar_tile_row_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lookup-or-insert in the table of the row's kind
    function automatic t_slot claim_slot(input logic sprite, input t_pal pal);
        int used;
        used = sprite ? sprite_slots_used : tile_slots_used;
        for (int i = 0; i < used; i++) begin
            if (sprite ? (sprite_pal_of_slot[i] == pal) : (tile_pal_of_slot[i] == pal))
                return t_slot'(i);
        end
        if (used >= SLOT_COUNT)
            return t_slot'(SLOT_COUNT - 1);
        if (sprite) begin
            sprite_pal_of_slot[used] = pal;
            sprite_slots_used = used + 1;
        end else begin
            tile_pal_of_slot[used] = pal;
            tile_slots_used = used + 1;
        end
        return t_slot'(used);
    endfunction

    function automatic void expect_row_pixels(input t_row r);
        t_slot  slot;
        int     n;
        t_pixel p;
        slot = claim_slot(r.cmd == CMD_SPRITE, r.pal);
        n = (r.cmd == CMD_SPRITE) ? 16 : 8;
        for (int k = 0; k < n; k++) begin
            if (r.cmd == CMD_SPRITE)
                p.value = {r.plane_d[15-k], r.plane_c[15-k], r.plane_b[15-k], r.plane_a[15-k]};
            else
                p.value = {r.plane_b[15-k], r.plane_b[7-k], r.plane_a[15-k], r.plane_a[7-k]};
            p.cram   = {1'b0, r.pal, 4'b0000} + {5'b00000, p.value}
                     + ((r.cmd == CMD_SPRITE) ? 9'h100 : 9'h000);
            p.transp = (r.cmd == CMD_SPRITE) && (p.value == 4'd0);
            p.slot   = slot;
            p.last   = (k == n - 1);
            pixels_due.push_back(p);
        end
    endfunction

    function automatic t_row make_row(input logic cmd, input t_pal pal, input logic [15:0] a,
                                      input logic [15:0] b, input logic [15:0] c,
                                      input logic [15:0] d);
        t_row r;
        r = '{cmd: cmd, pal: pal, plane_a: a, plane_b: b, plane_c: c, plane_d: d};
        return r;
    endfunction

    // source side
    always @(posedge i_clk) begin : src_drive
        logic  next_valid;
        t_row  r;
        if (i_rst_n) begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expect_row_pixels(row_on_bus);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_hold > 0) begin
                    src_hold <= src_hold - 1;
                end else if (rows_pending.size() > 0) begin
                    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
                        src_hold <= $urandom_range(0, 7);
                    end else begin
                        r = rows_pending.pop_front();
                        row_on_bus <= r;
                        s_tdata    <= {4'b0000, r.plane_d, r.plane_c, r.plane_b, r.plane_a, r.pal};
                        s_tuser    <= r.cmd;
                        next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // sink side: stalls and checking
    always @(posedge i_clk) begin : sink_check
        t_pixel want;
        t_pixel got;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = '{value: m_tdata[3:0], cram: m_tdata[12:4], transp: m_tuser,
                        slot: m_tdata[16:13], last: m_tlast};
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: value %0d cram %0d transp %0b slot %0d %s %0b",
                                 got.value, got.cram, got.transp, got.slot, "last", got.last);
                end else begin
                    want = pixels_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("pixel mismatch: expected value %0d cram %0d %s %0b %s %0d %s %0b",
                                     want.value, want.cram, "transp", want.transp,
                                     "slot", want.slot, "last", want.last);
                            $display("                got      value %0d cram %0d %s %0b %s %0d %s %0b",
                                     got.value, got.cram, "transp", got.transp,
                                     "slot", got.slot, "last", got.last);
                        end
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_tready  <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_gap_pct) begin
                sink_hold <= $urandom_range(0, 7);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // cycle count, idling mood and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && rows_pending.size() < CALM_ROWS)
            calm <= 1'b1;
        if (cycles % 64 == 0) begin
            // occasional spells with no idling at all
            src_gap_pct  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            sink_gap_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] mask;
        // directed rows: extremes, both kinds, repeated palettes
        rows_pending.push_back(make_row(CMD_TILE, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_TILE, 4'd15, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        rows_pending.push_back(make_row(CMD_TILE, 4'd7, 16'hAA55, 16'h33CC, 16'hFFFF, 16'hFFFF));
        rows_pending.push_back(make_row(CMD_TILE, 4'd7, 16'h00FF, 16'hFF00, 16'h1234, 16'h5678));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd3, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd3, 16'h8001, 16'h4002, 16'h2004, 16'h1008));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd0, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_TILE, 4'd15, 16'h8080, 16'h0101, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_TILE, 4'd0, 16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000));
        rows_pending.push_back(make_row(CMD_SPRITE, 4'd9, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
        for (int i = 0; i < RANDOM_ROWS; i++) begin
            // sparse planes now and then, for runs of transparent sprite pixels
            mask = ($urandom_range(0, 3) == 0) ? 16'($urandom & $urandom) : 16'hFFFF;
            rows_pending.push_back(make_row(1'($urandom_range(0, 1)), t_pal'($urandom_range(0, 15)),
                                            16'($urandom) & mask, 16'($urandom) & mask,
                                            16'($urandom) & mask, 16'($urandom) & mask));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (rows_pending.size() != 0 || s_tvalid);
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
